// ===== hw/rtl/olst_pkg.sv =====
// Shared constants, operation codes and types for the ordered list store.
package olst_pkg;

   // Store geometry.
   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int KIND_W = 4;
   localparam int STAT_W = 2;
   localparam int TALLY_W = 5;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd4;
   localparam logic [KIND_W-1:0] KIND_SEARCH     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_COUNT      = 4'd6;
   localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 4'd7;
   localparam logic [KIND_W-1:0] KIND_PEEK_BACK  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_LENGTH     = 4'd9;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

   // Commands broadcast to every cell.
   localparam logic [1:0] CMD_HOLD      = 2'd0;
   localparam logic [1:0] CMD_SHIFT_IN  = 2'd1;  // every cell takes its front neighbor
   localparam logic [1:0] CMD_SHIFT_OUT = 2'd2;  // cells at or after pos take back neighbor
   localparam logic [1:0] CMD_LOAD      = 2'd3;  // the cell at pos takes the value

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/olst_cell.sv =====
// One storage cell of the list: holds an entry, shifts with its neighbors, compares.
module olst_cell (
   input  logic                        clock,
   input  logic [olst_pkg::IDX_W-1:0]  cell_idx,
   input  logic [olst_pkg::DATA_W-1:0] key,
   input  olst_pkg::cell_cmd_type      cmd,
   input  logic [olst_pkg::DATA_W-1:0] prev_data,
   input  logic [olst_pkg::DATA_W-1:0] next_data,
   output logic [olst_pkg::DATA_W-1:0] data_out,
   output logic                        match_out
);
   import olst_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              match_ff;
   logic              match_in;

   // Next entry value from the broadcast command.
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CMD_SHIFT_IN: begin
            data_in = prev_data;
         end
         CMD_SHIFT_OUT: begin
            if (cell_idx >= cmd.pos) begin
               data_in = next_data;
            end
         end
         CMD_LOAD: begin
            if (cell_idx == cmd.pos) begin
               data_in = cmd.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Local compare against the latched key.
   assign match_in = (data_ff == key);

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;

endmodule

// ===== hw/rtl/olst_ctrl.sv =====
// Sequencer of the list: latches a request, reads the cell matches, issues the cell command.
module olst_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [olst_pkg::DATA_W-1:0]   req_tdata,
   input  logic [olst_pkg::KIND_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [olst_pkg::DATA_W-1:0]   rsp_element,
   output logic [olst_pkg::TALLY_W-1:0]  rsp_tally,
   output logic [olst_pkg::STAT_W-1:0]   rsp_status,
   output logic [olst_pkg::DATA_W-1:0]   key,
   output olst_pkg::cell_cmd_type        cmd,
   input  logic [olst_pkg::DATA_W-1:0]   cell_data [olst_pkg::DEPTH],
   input  logic [olst_pkg::DEPTH-1:0]    cell_match
);
   import olst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [DATA_W-1:0]  element_ff, element_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;

   logic               accept;
   logic               commit;
   logic [DEPTH-1:0]   hit_vec;
   logic [CNT_W-1:0]   hit_cnt;
   logic [IDX_W-1:0]   first_pos;
   logic               any_hit;
   logic [CNT_W-1:0]   last_cnt;
   logic [IDX_W-1:0]   back_idx;
   logic               is_empty;
   logic               is_full;
   logic [CNT_W-1:0]   tally_cnt;
   logic [31:0]        tally_wide;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign commit     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign is_empty   = (used_ff == '0);
   assign is_full    = (used_ff == CNT_W'(DEPTH));
   assign last_cnt   = used_ff - CNT_W'(1);
   assign back_idx   = last_cnt[IDX_W-1:0];

   // Matches limited to live entries, then first position and count.
   always_comb begin
      hit_cnt   = '0;
      first_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_vec[i] = cell_match[i] && (CNT_W'(i) < used_ff);
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            first_pos = IDX_W'(i);
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         hit_cnt = hit_cnt + CNT_W'(hit_vec[i]);
      end
   end
   assign any_hit = |hit_vec;

   // Operation decode: result fields, next length and cell command.
   always_comb begin
      status_in  = STAT_OK;
      element_in = '0;
      tally_cnt  = used_ff;
      used_in    = used_ff;
      cmd.op     = CMD_HOLD;
      cmd.pos    = '0;
      cmd.value  = key_ff;
      case (kind_ff)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               used_in   = used_ff + CNT_W'(1);
               tally_cnt = used_in;
               if (kind_ff == KIND_PUSH_FRONT) begin
                  cmd.op = CMD_SHIFT_IN;
               end else begin
                  cmd.op  = CMD_LOAD;
                  cmd.pos = used_ff[IDX_W-1:0];
               end
            end
         end
         KIND_REMOVE, KIND_SEARCH: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
               tally_cnt = '0;
            end else if (!any_hit) begin
               status_in = STAT_NOTFOUND;
            end else begin
               element_in = key_ff;
               tally_cnt  = CNT_W'(first_pos);
               if (kind_ff == KIND_REMOVE) begin
                  cmd.op  = CMD_SHIFT_OUT;
                  cmd.pos = first_pos;
                  used_in = last_cnt;
               end
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
               tally_cnt = '0;
            end else begin
               used_in   = last_cnt;
               tally_cnt = last_cnt;
               if (kind_ff == KIND_POP_FRONT) begin
                  element_in = cell_data[0];
                  cmd.op     = CMD_SHIFT_OUT;
               end else begin
                  element_in = cell_data[back_idx];
               end
            end
         end
         KIND_COUNT: begin
            tally_cnt = hit_cnt;
         end
         KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
               tally_cnt = '0;
            end else if (kind_ff == KIND_PEEK_FRONT) begin
               element_in = cell_data[0];
            end else begin
               element_in = cell_data[back_idx];
            end
         end
         default: begin
            tally_cnt = used_ff;
         end
      endcase
      if (!commit) begin
         cmd.op  = CMD_HOLD;
         used_in = used_ff;
      end
   end

   // The tally field keeps the low five bits of the count.
   assign tally_wide = 32'(tally_cnt);
   assign tally_in   = tally_wide[TALLY_W-1:0];

   // Sequencer and request latch.
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
               kind_in  = req_tuser;
               key_in   = req_tdata;
            end
         end
         S_CMP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded on commit, emptied when the beat is taken.
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      key_ff  <= key_in;
      if (commit) begin
         status_ff  <= status_in;
         element_ff <= element_in;
         tally_ff   <= tally_in;
      end
   end

   assign key         = key_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_tally   = tally_ff;

   // The length never exceeds the capacity.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(DEPTH))
      else $error("list length above capacity");

   // Cells only move during the execute step.
   a_cmd_exec: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != CMD_HOLD) |-> (state_ff == S_EXEC))
      else $error("cell command outside execute step");

   // A refused insert leaves the length unchanged.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (commit && is_full && (kind_ff == KIND_PUSH_FRONT || kind_ff == KIND_PUSH_BACK))
      |=> (used_ff == $past(used_ff)))
      else $error("insert into full list changed length");

   // An accepted beat always moves on to the compare step.
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CMP))
      else $error("accepted beat did not reach compare step");

endmodule

// ===== hw/rtl/ordered_list_store_top.sv =====
// Top level of the ordered list store: a row of storage cells and its sequencer.
//
// The store keeps up to 16 signed 32-bit values in order in a row of cells;
// each request beat on req_ names one operation in req_tuser and carries its
// operand in req_tdata, and gives exactly one response beat on rsp_. One
// request is processed at a time, in steps: the accept step, a compare
// step in which every cell compares its entry with the operand into a
// match register, and an execute step that reads those matches, shifts or
// loads the cells and fills the output register. A new request is taken
// only after the execute step of the last one; the next request is accepted
// while a finished response still waits, but its execute step waits for the
// output register. Insert into a full store is refused with status full.
module ordered_list_store_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operand[31:0]
   input  logic [3:0]  req_tuser,   // kind[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // element[31:0], tally[36:32], zero fill[39:37]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import olst_pkg::*;

   logic [DATA_W-1:0]  cell_data [DEPTH];
   logic [DEPTH-1:0]   cell_match;
   logic [DATA_W-1:0]  key;
   cell_cmd_type       cmd;
   logic [DATA_W-1:0]  rsp_element;
   logic [TALLY_W-1:0] rsp_tally;

   // Sequencer.
   olst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_element (rsp_element),
      .rsp_tally   (rsp_tally),
      .rsp_status  (rsp_tuser),
      .key         (key),
      .cmd         (cmd),
      .cell_data   (cell_data),
      .cell_match  (cell_match)
   );

   // Row of cells; the front cell shifts in the operand, the back cell keeps its own entry.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] prev_data;
      logic [DATA_W-1:0] next_data;

      if (i == 0) begin : g_front
         assign prev_data = cmd.value;
      end else begin : g_mid_prev
         assign prev_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign next_data = cell_data[i];
      end else begin : g_mid_next
         assign next_data = cell_data[i+1];
      end

      olst_cell u_cell (
         .clock     (clock),
         .cell_idx  (IDX_W'(i)),
         .key       (key),
         .cmd       (cmd),
         .prev_data (prev_data),
         .next_data (next_data),
         .data_out  (cell_data[i]),
         .match_out (cell_match[i])
      );
   end

   // Response packing.
   assign rsp_tdata = {3'b000, rsp_tally, rsp_element};

endmodule
